[design/tw_rl_pkg.sv]
`default_nettype none
package tw_rl_pkg;
  localparam int unsigned MIN_INTERVAL = 60;
  localparam int unsigned IVL_W = 20;
  localparam int unsigned MAXR_W = 24;
  localparam int unsigned SENDERS = 1024;
  localparam int unsigned COUNT_WIDTH = 24;
  localparam logic [0:0] CFG_INTERVAL = 1'd0;
  localparam logic [0:0] CFG_MAX_RCPT = 1'd1;

  // one classified item in the queue between front and back
  typedef struct packed {
    logic        has_sender;
    logic [15:0] sender_id;
    logic [15:0] recipient_count;
    logic [31:0] epoch;
  } job_t;
endpackage
`default_nettype wire

[design/tw_rl_if.sv]
`default_nettype none
interface tw_rl_in_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic        has_sender;
  logic [9:0]  sender_id;
  logic [15:0] recipient_count;
  logic [31:0] now_seconds;
  modport source (output valid, has_sender, sender_id, recipient_count, now_seconds,
                  input ready);
  modport sink (input valid, has_sender, sender_id, recipient_count, now_seconds,
                output ready);
endinterface

interface tw_rl_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic over_limit;
  modport source (output valid, over_limit, input ready);
  modport sink (input valid, over_limit, output ready);
endinterface
`default_nettype wire

[design/tw_rl_ram.sv]
`default_nettype none
module tw_rl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/tw_rl_front.sv]
`default_nettype none
// accepts items and, for items with a sender, divides time by the half interval, one quotient bit a cycle
module tw_rl_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  tw_rl_in_if.sink                 in_ch,
  input  wire logic [19:0]         interval_r,
  input  wire logic                q_full,
  output logic                     q_push,
  output tw_rl_pkg::job_t          q_data
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  bit_r, bit_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [19:0] rem_r, rem_nxt;
  logic [19:0] half_r;
  logic        has_r;
  logic [9:0]  id_r;
  logic [15:0] rc_r;
  logic [20:0] trial;
  logic [19:0] ivl;

  assign ivl = (interval_r < 20'(tw_rl_pkg::MIN_INTERVAL)) ?
               20'(tw_rl_pkg::MIN_INTERVAL) : interval_r;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign trial = {rem_r, quo_r[31]};

  always_comb begin
    state_nxt = state_r;
    bit_nxt = bit_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    q_push = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.has_sender ? ST_DIV : ST_PUSH;
          bit_nxt = 6'd0;
          quo_nxt = in_ch.now_seconds;
          rem_nxt = '0;
        end
      end
      ST_DIV: begin
        // restoring step: dividend shifts out of quo_r as quotient bits shift in
        if (trial >= {1'b0, half_r}) begin
          rem_nxt = 20'(trial - {1'b0, half_r});
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = trial[19:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        bit_nxt = bit_r + 6'd1;
        if (bit_r == 6'd31) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_data.has_sender = has_r;
    q_data.sender_id = 16'(id_r);
    q_data.recipient_count = rc_r;
    q_data.epoch = quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bit_r <= bit_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (in_ch.valid && in_ch.ready) begin
      has_r <= in_ch.has_sender;
      id_r <= in_ch.sender_id;
      rc_r <= in_ch.recipient_count;
      half_r <= {1'b0, ivl[19:1]};
    end
  end
endmodule
`default_nettype wire

[design/tw_rl_queue.sv]
`default_nettype none
module tw_rl_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  tw_rl_pkg::job_t push_data,
  output logic            full,
  input  wire logic       pop,
  output logic            not_empty,
  output tw_rl_pkg::job_t pop_data
);
  tw_rl_pkg::job_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= 2'(cnt_r + 2'(push) - 2'(pop));
    end
    if (push) slot_r[wp_r] <= push_data;
  end
endmodule
`default_nettype wire

[design/tw_rl_back.sv]
`default_nettype none
// table read-modify-write for items with a sender; a clearing pass after reset zeroes every entry
module tw_rl_back (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  tw_rl_pkg::job_t q_data,
  output logic            q_pop,
  input  wire logic [23:0] max_r,
  output logic            clearing,
  tw_rl_out_if.source     out_ch
);
  localparam int unsigned SENDERS = tw_rl_pkg::SENDERS;
  localparam int unsigned COUNT_WIDTH = tw_rl_pkg::COUNT_WIDTH;
  localparam int unsigned AW = (SENDERS > 1) ? $clog2(SENDERS) : 1;
  localparam int unsigned EW = 32 + 2 * COUNT_WIDTH;
  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]    state_r;
  logic [AW:0]   clr_r;
  logic [AW-1:0] addr_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata, rdata;
  tw_rl_pkg::job_t job_r;
  logic          ov_r, oval_r;

  logic [31:0] tag;
  logic [COUNT_WIDTH-1:0] cur, prev, cur0, prev0;
  logic [COUNT_WIDTH:0] csum, tot;
  logic [COUNT_WIDTH-1:0] cnew;

  assign clearing = (state_r == ST_CLR);
  assign out_ch.valid = oval_r;
  assign out_ch.over_limit = ov_r;
  assign q_pop = (state_r == ST_IDLE) && q_valid && (!oval_r || out_ch.ready);

  assign tag = rdata[EW-1 -: 32];
  assign cur = rdata[2*COUNT_WIDTH-1 -: COUNT_WIDTH];
  assign prev = rdata[COUNT_WIDTH-1:0];

  always_comb begin
    cur0 = cur;
    prev0 = prev;
    if (job_r.epoch != tag) begin
      prev0 = (job_r.epoch == 32'(tag + 32'd1)) ? cur : '0;
      cur0 = '0;
    end
    csum = {1'b0, cur0} + (COUNT_WIDTH + 1)'(job_r.recipient_count);
    cnew = csum[COUNT_WIDTH] ? '1 : csum[COUNT_WIDTH-1:0];
    tot = {1'b0, cnew} + {1'b0, prev0};
  end

  always_comb begin
    we = 1'b0;
    waddr = addr_r;
    wdata = {job_r.epoch, cnew, prev0};
    if (state_r == ST_CLR) begin
      we = 1'b1;
      waddr = clr_r[AW-1:0];
      wdata = '0;
    end else if (state_r == ST_UPD) begin
      we = 1'b1;
    end
  end

  tw_rl_ram #(.WIDTH(EW), .DEPTH(SENDERS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(addr_r), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      oval_r <= 1'b0;
    end else begin
      if ((q_pop && !q_data.has_sender) || (state_r == ST_UPD)) begin
        oval_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        oval_r <= 1'b0;
      end
      case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + (AW + 1)'(1);
          if (clr_r == (AW + 1)'(SENDERS - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_pop && q_data.has_sender) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: state_r <= ST_UPD;
        ST_UPD: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
    if (q_pop) begin
      job_r <= q_data;
      addr_r <= q_data.sender_id[AW-1:0];
      ov_r <= 1'b0;
    end
    if (state_r == ST_UPD) ov_r <= (tot > (COUNT_WIDTH + 1)'(max_r));
  end
endmodule
`default_nettype wire

[design/two_window_sender_rate_limiter.sv]
`default_nettype none
// channel | direction | fields
// in_     | sink      | has_sender, sender_id, recipient_count, now_seconds
// out_    | source    | over_limit
// cfg_    | write     | cfg_index 0 interval_seconds, 1 max_recipients
// front: accept, bit-serial divide (one quotient bit each step, skipped without a sender), queue push
// back: table read, update/write and result register with a sender; without one, result register only
// front takes no new item until the last is pushed; with a sender the bit-serial divider sets the rate
// after reset a clearing pass over all SENDERS entries zeroes the table; items wait in the front
// a stalled result holds the back end; the 2-entry queue lets the front keep dividing
module two_window_sender_rate_limiter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tw_rl_in_if.sink         in_ch,
  tw_rl_out_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_wdata
);
  logic [19:0] interval_r;
  logic [23:0] max_r;
  logic q_full, q_push, q_pop, q_ne, clearing;
  tw_rl_pkg::job_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 20'd60;
      max_r <= 24'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        tw_rl_pkg::CFG_INTERVAL: interval_r <= cfg_wdata[19:0];
        tw_rl_pkg::CFG_MAX_RCPT: max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tw_rl_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .interval_r(interval_r),
    .q_full(q_full | clearing), .q_push(q_push), .q_data(q_in)
  );

  tw_rl_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
  );

  tw_rl_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_data(q_out), .q_pop(q_pop),
    .max_r(max_r), .clearing(clearing), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

[design/tw_rl_checker.sv]
`default_nettype none
module tw_rl_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_over_limit
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_over_limit))
    else $error("result dropped under stall");
  a_no_back2back_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front took two items in a row");
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result right after reset");
endmodule

bind two_window_sender_rate_limiter tw_rl_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_over_limit(out_ch.over_limit)
);
`default_nettype wire

[test/two_window_sender_rate_limiter_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module two_window_sender_rate_limiter_test;
  localparam int unsigned TABLE_SIZE = 1024;
  localparam logic [23:0] COUNT_CEIL = 24'hFFFFFF;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = tw_rl_pkg::CFG_INTERVAL;
  logic [23:0] cfg_wdata = '0;

  tw_rl_in_if in_ch (clk);
  tw_rl_out_if out_ch (clk);

  two_window_sender_rate_limiter i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // shadow copy of the sender table and registers
  logic [tw_rl_pkg::IVL_W-1:0]  win_seconds;
  logic [tw_rl_pkg::MAXR_W-1:0] rcpt_limit;
  logic [31:0]       tag_epoch [TABLE_SIZE];
  logic [23:0]       cur_cnt [TABLE_SIZE];
  logic [23:0]       prev_cnt [TABLE_SIZE];

  bit expected_verdicts[$];
  bit quiet = 1'b0;
  int fail_count = 0;
  int items_sent = 0;
  int rejects_seen = 0;
  int results_seen = 0;
  logic [31:0] clock_s;

  function automatic bit predict_verdict(bit has, logic [9:0] id, logic [15:0] rc,
                                         logic [31:0] now);
    logic [31:0] span;
    logic [31:0] half;
    logic [31:0] ep;
    logic [24:0] cur;
    logic [24:0] prev;
    if (!has) return 1'b0;
    span = (win_seconds < tw_rl_pkg::MIN_INTERVAL) ? tw_rl_pkg::MIN_INTERVAL :
           32'(win_seconds);
    half = span / 2;
    ep = now / half;
    cur = {1'b0, cur_cnt[id]};
    prev = {1'b0, prev_cnt[id]};
    if (ep != tag_epoch[id]) begin
      if ({1'b0, ep} == {1'b0, tag_epoch[id]} + 33'd1) prev = cur;
      else prev = '0;
      cur = '0;
      tag_epoch[id] = ep;
    end
    cur = cur + rc;
    if (cur > {1'b0, COUNT_CEIL}) cur = {1'b0, COUNT_CEIL};
    cur_cnt[id] = cur[23:0];
    prev_cnt[id] = prev[23:0];
    return (cur + prev) > {1'b0, rcpt_limit};
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.over_limit) rejects_seen++;
      if (expected_verdicts.size() == 0) begin
        $error("over_limit: no item pending, got %0b", out_ch.over_limit);
        fail_count++;
      end else begin
        bit want;
        want = expected_verdicts.pop_front();
        if (out_ch.over_limit !== want) begin
          $error("over_limit: expected %0b actual %0b", want, out_ch.over_limit);
          fail_count++;
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(bit has, logic [9:0] id, logic [15:0] rc, logic [31:0] now);
    while (!quiet && $urandom_range(99) < 35) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.has_sender = has;
    in_ch.sender_id = id;
    in_ch.recipient_count = rc;
    in_ch.now_seconds = now;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_verdicts.push_back(predict_verdict(has, id, rc, now));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == tw_rl_pkg::CFG_INTERVAL) win_seconds = val[tw_rl_pkg::IVL_W-1:0];
    else rcpt_limit = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_directed_defaults();
    send_item(1'b0, 10'd3, 16'hFFFF, 32'd0);
    send_item(1'b1, 10'd0, 16'd100, 32'd0);
    send_item(1'b1, 10'd0, 16'd1, 32'd29);
    // one epoch on: counts shift into previous
    send_item(1'b1, 10'd0, 16'd0, 32'd30);
    send_item(1'b1, 10'd0, 16'd0, 32'd60);
    send_item(1'b1, 10'd0, 16'd50, 32'd95);
    // long gap clears both
    send_item(1'b1, 10'd0, 16'd10, 32'd400);
    // time going backwards
    send_item(1'b1, 10'd0, 16'd99, 32'd10);
    send_item(1'b1, 10'd1023, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(1'b1, 10'd1023, 16'd0, 32'hFFFF_FFFF);
    send_item(1'b0, 10'd1023, 16'd0, 32'hFFFF_FFFF);
    // short interval acts as the minimum
    write_reg(tw_rl_pkg::CFG_INTERVAL, 24'd0);
    write_reg(tw_rl_pkg::CFG_MAX_RCPT, 24'd0);
    send_item(1'b1, 10'd7, 16'd0, 32'd100);
    send_item(1'b1, 10'd7, 16'd1, 32'd119);
    send_item(1'b1, 10'd7, 16'd0, 32'd120);
    send_item(1'b1, 10'd7, 16'd0, 32'd150);
    write_reg(tw_rl_pkg::CFG_INTERVAL, 24'hFFFFFF);
    write_reg(tw_rl_pkg::CFG_MAX_RCPT, 24'hFFFFFF);
    send_item(1'b1, 10'h2AA, 16'hAAAA, 32'hAAAA_AAAA);
    send_item(1'b1, 10'h155, 16'h5555, 32'h5555_5555);
  endtask

  task automatic test_saturation();
    write_reg(tw_rl_pkg::CFG_INTERVAL, 24'd604800);
    write_reg(tw_rl_pkg::CFG_MAX_RCPT, 24'hFFFFFF);
    quiet = 1'b1;
    repeat (260) send_item(1'b1, 10'd5, 16'hFFFF, 32'd1000);
    quiet = 1'b0;
    send_item(1'b1, 10'd5, 16'd1, 32'd302400);
    send_item(1'b1, 10'd5, 16'd0, 32'd302401);
  endtask

  task automatic test_random_traffic(logic [23:0] ivl, logic [23:0] lim, int n);
    logic [9:0] pool [4];
    logic [31:0] half;
    logic [31:0] step;
    logic [15:0] rc;
    logic [9:0] id;
    int r;
    write_reg(tw_rl_pkg::CFG_INTERVAL, ivl);
    write_reg(tw_rl_pkg::CFG_MAX_RCPT, lim);
    half = ((win_seconds < tw_rl_pkg::MIN_INTERVAL) ? tw_rl_pkg::MIN_INTERVAL :
            32'(win_seconds)) / 2;
    foreach (pool[k]) pool[k] = 10'($urandom_range(1023));
    clock_s = $urandom();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 65) step = $urandom_range(half / 4);
      else if (r < 85) step = half + $urandom_range(half / 2);
      else if (r < 95) step = $urandom();
      else step = -32'($urandom_range(2 * half));
      clock_s = clock_s + step;
      id = ($urandom_range(99) < 75) ? pool[$urandom_range(3)] : 10'($urandom_range(1023));
      if ($urandom_range(99) < 60)
        rc = 16'($urandom_range((lim < 24'd4) ? 4 : 32'(lim) / 3 + 1));
      else
        rc = 16'($urandom());
      send_item($urandom_range(99) >= 10, id, rc, clock_s);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.has_sender = 1'b0;
    in_ch.sender_id = '0;
    in_ch.recipient_count = '0;
    in_ch.now_seconds = '0;
    out_ch.ready = 1'b0;
    win_seconds = 20'd60;
    rcpt_limit = 24'd100;
    foreach (tag_epoch[k]) begin
      tag_epoch[k] = '0;
      cur_cnt[k] = '0;
      prev_cnt[k] = '0;
    end
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_directed_defaults();
    test_saturation();
    test_random_traffic(24'd60, 24'd100, 210);
    test_random_traffic(24'd604800, 24'hFFFFFF, 120);
    test_random_traffic(24'd59, 24'd0, 120);
    test_random_traffic(24'd61, 24'd5, 120);
    quiet = 1'b1;
    test_random_traffic(24'($urandom_range(604800, 60)), 24'($urandom_range(200000)), 100);
    quiet = 1'b0;
    test_random_traffic(24'($urandom_range(3600, 60)), 24'($urandom_range(5000)), 100);
    wait_drained();

    $display("covered %0d items, %0d results (%0d rejected) over directed, saturation",
             items_sent, results_seen, rejects_seen);
    $display("and six random register settings including both extremes");
    if (fail_count == 0) begin
      $display("two_window_sender_rate_limiter_test OK");
    end else begin
      $display("two_window_sender_rate_limiter_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("two_window_sender_rate_limiter_test NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
